[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the calibration table RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

[rtl/ctfl_pkg.sv]
// ----------------------------------------------------------------------------
// ctfl_pkg
// Types and codes shared by the calibration table controller and datapath.
// ----------------------------------------------------------------------------
package ctfl_pkg;

    localparam int KEY_W = 12;
    localparam int VAL_W = 16;
    localparam int CNT_W = 7;
    localparam int OP_W  = 2;
    localparam int ST_W  = 2;

    localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] shutter;
        logic [VAL_W-1:0] gain;
    } entry_t;

    typedef struct packed {
        logic latch;
        logic scan_start;
        logic scan_step;
        logic update;
        logic set_full;
        logic set_empty;
        logic clear;
        logic shift_start;
        logic shift_step;
        logic load_out;
    } ctfl_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            empty;
        logic            full;
        logic            scan_done;
        logic            match;
        logic            shift_last;
    } ctfl_sts_t;

endpackage

[rtl/ctfl_dpath.sv]
// ----------------------------------------------------------------------------
// ctfl_dpath
// Entry memory, scan and shift pointers, result staging and output register.
// ----------------------------------------------------------------------------
module ctfl_dpath
    import ctfl_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ctfl_cmd_t        cmd,
    output ctfl_sts_t        sts,
    input  logic [OP_W-1:0]  in_opcode,
    input  logic [KEY_W-1:0] in_band,
    input  logic [VAL_W-1:0] in_shutter,
    input  logic [VAL_W-1:0] in_gain,
    output logic [ST_W-1:0]  status,
    output logic [VAL_W-1:0] shutter_out,
    output logic [VAL_W-1:0] gain_out,
    output logic [CNT_W-1:0] entry_count
);

    `include "assert_macros.svh"

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    entry_t           mem [TABLE_DEPTH];

    logic [OP_W-1:0]  op_reg;
    logic [KEY_W-1:0] band_reg;
    logic [VAL_W-1:0] shutter_in_reg;
    logic [VAL_W-1:0] gain_in_reg;

    logic [CW-1:0]    used_reg;
    logic [CW-1:0]    ptr_reg;
    logic             pend_reg;
    logic [CW-1:0]    p_reg;
    logic             match_reg;
    logic [CW-1:0]    sptr_reg;
    logic [AW-1:0]    dst_reg;

    entry_t           rd_data_reg;
    entry_t           prev_reg;

    logic [ST_W-1:0]  stage_status_reg;
    logic [VAL_W-1:0] stage_shutter_reg;
    logic [VAL_W-1:0] stage_gain_reg;

    logic [ST_W-1:0]  out_status_reg;
    logic [VAL_W-1:0] out_shutter_reg;
    logic [VAL_W-1:0] out_gain_reg;
    logic [CNT_W-1:0] out_count_reg;

    logic             key_eq;
    logic             hit;
    logic             scan_end;
    logic             shift_more;
    logic             shift_last;
    logic             use_rd;
    logic [CW-1:0]    sptr_dec;
    entry_t           new_entry;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    entry_t           wr_data;

    assign key_eq     = (rd_data_reg.key == band_reg);
    assign hit        = pend_reg && (rd_data_reg.key >= band_reg);
    assign scan_end   = !hit && (ptr_reg == used_reg);
    assign shift_more = (sptr_reg > p_reg);
    assign shift_last = !shift_more && !pend_reg;
    assign use_rd     = scan_end || key_eq || (ptr_reg == CW'(1));
    assign sptr_dec   = sptr_reg - CW'(1);
    assign new_entry  = '{key: band_reg, shutter: shutter_in_reg, gain: gain_in_reg};

    assign sts.op         = op_reg;
    assign sts.empty      = (used_reg == '0);
    assign sts.full       = (used_reg == DEPTH_C);
    assign sts.scan_done  = hit || scan_end;
    assign sts.match      = match_reg;
    assign sts.shift_last = shift_last;

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = ptr_reg[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = p_reg[AW-1:0];
        wr_data = new_entry;
        if (cmd.scan_step && !hit && !scan_end)
        begin
            rd_en = 1'b1;
        end
        if (cmd.shift_step)
        begin
            if (shift_more)
            begin
                rd_en   = 1'b1;
                rd_addr = sptr_dec[AW-1:0];
            end
            if (pend_reg)
            begin
                wr_en   = 1'b1;
                wr_addr = dst_reg;
                wr_data = rd_data_reg;
            end
            else if (!shift_more)
            begin
                wr_en = 1'b1;
            end
        end
        if (cmd.update)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            ptr_reg   <= '0;
            pend_reg  <= 1'b0;
            p_reg     <= '0;
            match_reg <= 1'b0;
            sptr_reg  <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                used_reg <= '0;
            end
            else if (cmd.shift_step && shift_last)
            begin
                used_reg <= used_reg + CW'(1);
            end

            if (cmd.scan_start)
            begin
                ptr_reg  <= '0;
                pend_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                if (hit)
                begin
                    p_reg     <= ptr_reg - CW'(1);
                    match_reg <= key_eq;
                end
                else if (scan_end)
                begin
                    p_reg     <= ptr_reg;
                    match_reg <= 1'b0;
                end
                else
                begin
                    ptr_reg  <= ptr_reg + CW'(1);
                    pend_reg <= 1'b1;
                end
            end
            else if (cmd.shift_start)
            begin
                sptr_reg <= used_reg;
                pend_reg <= 1'b0;
            end
            else if (cmd.shift_step)
            begin
                if (shift_more)
                begin
                    sptr_reg <= sptr_dec;
                    pend_reg <= 1'b1;
                end
                else
                begin
                    pend_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg            <= in_opcode;
            band_reg          <= in_band;
            shutter_in_reg    <= in_shutter;
            gain_in_reg       <= in_gain;
            stage_status_reg  <= ST_OK;
            stage_shutter_reg <= '0;
            stage_gain_reg    <= '0;
        end
        else if (cmd.set_empty)
        begin
            stage_status_reg <= ST_EMPTY;
        end
        else if (cmd.set_full)
        begin
            stage_status_reg <= ST_FULL;
        end
        else if (cmd.scan_step && (hit || scan_end) && (op_reg == OP_LOOKUP))
        begin
            stage_shutter_reg <= use_rd ? rd_data_reg.shutter : prev_reg.shutter;
            stage_gain_reg    <= use_rd ? rd_data_reg.gain : prev_reg.gain;
        end

        if (cmd.scan_step && pend_reg && !hit)
        begin
            prev_reg <= rd_data_reg;
        end

        if (cmd.shift_step && shift_more)
        begin
            dst_reg <= sptr_reg[AW-1:0];
        end

        if (cmd.load_out)
        begin
            out_status_reg  <= stage_status_reg;
            out_shutter_reg <= stage_shutter_reg;
            out_gain_reg    <= stage_gain_reg;
            out_count_reg   <= CNT_W'(used_reg);
        end
    end

    assign status      = out_status_reg;
    assign shutter_out = out_shutter_reg;
    assign gain_out    = out_gain_reg;
    assign entry_count = out_count_reg;

    `ASSERT_NEVER(a_used_range, clk, rst_n, used_reg > DEPTH_C, "entry count above depth")
    `ASSERT_CLK(a_scan_ptr, clk, rst_n, cmd.scan_step |-> (ptr_reg <= used_reg), "scan past end")
    `ASSERT_CLK(a_shift_ptr, clk, rst_n, cmd.shift_step |-> (sptr_reg >= p_reg), "shift below slot")

endmodule

[rtl/ctfl_ctrl.sv]
// ----------------------------------------------------------------------------
// ctfl_ctrl
// Operation sequencer: dispatch, scan, update or insert, result hand-off.
// ----------------------------------------------------------------------------
module ctfl_ctrl
    import ctfl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  ctfl_sts_t sts,
    output ctfl_cmd_t cmd
);

    `include "assert_macros.svh"

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_POST     = 3'd3;
    localparam logic [2:0] S_SHIFT    = 3'd4;
    localparam logic [2:0] S_RESULT   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (sts.op)
                    OP_WRITE:
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                    OP_LOOKUP:
                    begin
                        if (sts.empty)
                        begin
                            cmd.set_empty = 1'b1;
                            state_next    = S_RESULT;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_RESULT;
                    end
                    default:
                    begin
                        state_next = S_RESULT;
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                state_next = S_RESULT;
                if (sts.op == OP_WRITE)
                begin
                    if (sts.match)
                    begin
                        cmd.update = 1'b1;
                    end
                    else if (sts.full)
                    begin
                        cmd.set_full = 1'b1;
                    end
                    else
                    begin
                        cmd.shift_start = 1'b1;
                        state_next      = S_SHIFT;
                    end
                end
            end
            S_SHIFT:
            begin
                cmd.shift_step = 1'b1;
                if (sts.shift_last)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    `ASSERT_CLK(a_load_free, clk, rst_n, cmd.load_out |-> (!out_valid_reg || m_tready), "result overrun")
    `ASSERT_CLK(a_shift_room, clk, rst_n, (state_reg == S_SHIFT) |-> !sts.full, "insert into full table")

endmodule

[rtl/calibration_table_floor_lookup.sv]
// ----------------------------------------------------------------------------
// calibration_table_floor_lookup
// Ordered calibration table with write/update, floor lookup and clear.
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tuser: opcode; tdata: band, shutter, gain
// m_*       out  m_tvalid/m_tready  tuser: status; tdata: shutter, gain, count
//
// Lookup: one memory read per cycle while scanning.
// Write of a new key: scan to slot p, then shift entries up one per cycle
//   through the single-port-write entry memory.
// Clear, empty lookup and unused opcodes skip the scan. s_tready returns
//   in the cycle after the result loads. One item is in work at a time.
// Reset empties the table at once; entry contents are undefined until written.
// A waiting result holds in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module calibration_table_floor_lookup
    import ctfl_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // band[11:0], shutter_in[27:12], gain_in[43:28]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // shutter_out[15:0], gain_out[31:16], entry_count[38:32]
    output logic [1:0]  m_tuser    // status[1:0]
);

    ctfl_cmd_t        cmd;
    ctfl_sts_t        sts;
    logic [VAL_W-1:0] shutter_out;
    logic [VAL_W-1:0] gain_out;
    logic [CNT_W-1:0] entry_count;

    ctfl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ctfl_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_opcode   (s_tuser),
        .in_band     (s_tdata[11:0]),
        .in_shutter  (s_tdata[27:12]),
        .in_gain     (s_tdata[43:28]),
        .status      (m_tuser),
        .shutter_out (shutter_out),
        .gain_out    (gain_out),
        .entry_count (entry_count)
    );

    assign m_tdata = {1'b0, entry_count, gain_out, shutter_out};

endmodule

[tb/sv/calibration_table_floor_lookup_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calibration_table_floor_lookup_tb
// Sends write, lookup, clear and unused-opcode items through the stream
// ports, with random gaps on both sides and long output stalls. The table is
// filled past its depth, updated, cleared and searched near stored keys. Each
// result is checked against an ordered-table model kept in a scoreboard class.
// ----------------------------------------------------------------------------
module calibration_table_floor_lookup_tb;
    import ctfl_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int ITEM_TARGET = 1900;
    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_CYCLES = 700;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [VAL_W-1:0] shutter;
        logic [VAL_W-1:0] gain;
        logic [CNT_W-1:0] count;
    } table_result_t;

    class floor_table_predictor;
        logic [KEY_W-1:0] keys [TABLE_DEPTH];
        logic [VAL_W-1:0] shutters [TABLE_DEPTH];
        logic [VAL_W-1:0] gains [TABLE_DEPTH];
        int used;
        int mismatch_count;
        table_result_t pending_results[$];

        function new();
            used = 0;
            mismatch_count = 0;
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        function int first_not_below(logic [KEY_W-1:0] band);
            int p;
            p = 0;
            while (p < used && keys[p] < band)
                p++;
            return p;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] band,
                                   logic [VAL_W-1:0] shutter, logic [VAL_W-1:0] gain);
            table_result_t r;
            int p;
            int sel;
            r = '0;
            r.status = ST_OK;
            case (op)
                OP_WRITE:
                begin
                    p = first_not_below(band);
                    if (p < used && keys[p] == band)
                    begin
                        shutters[p] = shutter;
                        gains[p] = gain;
                    end
                    else if (used >= TABLE_DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        for (int i = used; i > p; i--)
                        begin
                            keys[i] = keys[i - 1];
                            shutters[i] = shutters[i - 1];
                            gains[i] = gains[i - 1];
                        end
                        keys[p] = band;
                        shutters[p] = shutter;
                        gains[p] = gain;
                        used++;
                    end
                end
                OP_LOOKUP:
                begin
                    if (used == 0)
                        r.status = ST_EMPTY;
                    else
                    begin
                        p = first_not_below(band);
                        if (p < used && keys[p] == band)
                            sel = p;
                        else if (p == 0)
                            sel = 0;
                        else
                            sel = p - 1;
                        r.shutter = shutters[sel];
                        r.gain = gains[sel];
                    end
                end
                OP_CLEAR:
                    used = 0;
                default:
                    ;
            endcase
            r.count = CNT_W'(used);
            pending_results.push_back(r);
        endfunction

        task flag_mismatch(string what);
            $display("MISMATCH at %0t: %s", $time, what);
            mismatch_count++;
        endtask

        task check_response(table_result_t got);
            table_result_t want;
            if (pending_results.size() == 0)
            begin
                flag_mismatch($sformatf("result with nothing outstanding, status %0d",
                                        got.status));
                return;
            end
            want = pending_results.pop_front();
            if (got.status != want.status)
                flag_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.shutter != want.shutter)
                flag_mismatch($sformatf("shutter_out %h, expected %h",
                                        got.shutter, want.shutter));
            if (got.gain != want.gain)
                flag_mismatch($sformatf("gain_out %h, expected %h", got.gain, want.gain));
            if (got.count != want.count)
                flag_mismatch($sformatf("entry_count %0d, expected %0d",
                                        got.count, want.count));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // band[11:0], shutter_in[27:12], gain_in[43:28]
    logic [1:0]  s_tuser;   // opcode[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // shutter_out[15:0], gain_out[31:16], entry_count[38:32]
    logic [1:0]  m_tuser;   // status[1:0]

    floor_table_predictor table_model;
    logic [KEY_W-1:0] written_keys[$];
    int items_issued;
    bit sender_fast;
    bit narrow_keys;
    logic [KEY_W-1:0] key_base;

    calibration_table_floor_lookup #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                table_model.note_request(s_tuser, s_tdata[11:0], s_tdata[27:12],
                                         s_tdata[43:28]);
            if (m_tvalid && m_tready)
                table_model.check_response(table_result_t'{m_tuser, m_tdata[15:0],
                                                           m_tdata[31:16], m_tdata[38:32]});
        end
    end

    task automatic issue_item(logic [OP_W-1:0] op, logic [KEY_W-1:0] band,
                              logic [VAL_W-1:0] shutter, logic [VAL_W-1:0] gain);
        int gap;
        bit held;
        gap = sender_fast ? 0 : $urandom_range(0, 19);
        @(negedge clk);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, gain, shutter, band};
        do
            @(posedge clk);
        while (!s_tready);
        if (op == OP_WRITE)
        begin
            held = 1'b0;
            foreach (written_keys[i])
                if (written_keys[i] == band)
                    held = 1'b1;
            if (!held && written_keys.size() < TABLE_DEPTH)
                written_keys.push_back(band);
        end
        else if (op == OP_CLEAR)
            written_keys.delete();
        if (op != OP_UNUSED)
            items_issued++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (table_model.outstanding() != 0)
            @(posedge clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_write_band();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 2 && written_keys.size() != 0)
            return written_keys[$urandom_range(0, written_keys.size() - 1)];
        if (pick == 2)
            return ($urandom_range(0, 1) != 0) ? {KEY_W{1'b1}} : {KEY_W{1'b0}};
        if (narrow_keys)
            return key_base + KEY_W'($urandom_range(0, 127));
        return KEY_W'($urandom);
    endfunction

    function automatic logic [KEY_W-1:0] pick_lookup_band();
        int pick;
        int offset;
        pick = $urandom_range(0, 9);
        if (pick < 6 && written_keys.size() != 0)
        begin
            offset = int'($urandom_range(0, 4)) - 2;
            return written_keys[$urandom_range(0, written_keys.size() - 1)] + KEY_W'(offset);
        end
        if (pick == 6)
            return ($urandom_range(0, 1) != 0) ? {KEY_W{1'b1}} : {KEY_W{1'b0}};
        return KEY_W'($urandom);
    endfunction

    task automatic run_episode();
        int fill_goal;
        int extra;
        int pick;
        narrow_keys = ($urandom_range(0, 1) != 0);
        key_base = KEY_W'($urandom);
        sender_fast = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 4) != 0)
            issue_item(OP_CLEAR, KEY_W'($urandom), VAL_W'($urandom), VAL_W'($urandom));
        fill_goal = ($urandom_range(0, 2) == 0) ? TABLE_DEPTH : $urandom_range(1, 40);
        while (written_keys.size() < fill_goal)
        begin
            if ($urandom_range(0, 9) < 7)
                issue_item(OP_WRITE, pick_write_band(), VAL_W'($urandom), VAL_W'($urandom));
            else
                issue_item(OP_LOOKUP, pick_lookup_band(), VAL_W'($urandom),
                           VAL_W'($urandom));
        end
        extra = $urandom_range(5, 40);
        repeat (extra)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                issue_item(OP_WRITE, pick_write_band(), VAL_W'($urandom), VAL_W'($urandom));
            else if (pick < 92)
                issue_item(OP_LOOKUP, pick_lookup_band(), VAL_W'($urandom),
                           VAL_W'($urandom));
            else if (pick < 96)
                issue_item(OP_UNUSED, KEY_W'($urandom), VAL_W'($urandom), VAL_W'($urandom));
            else
                issue_item(OP_CLEAR, KEY_W'($urandom), VAL_W'($urandom), VAL_W'($urandom));
        end
        if ($urandom_range(0, 3) == 0)
            wait_drained();
    endtask

    initial
    begin : result_sink
        int gap;
        int taken;
        bit fast;
        m_tready = 1'b0;
        taken = 0;
        fast = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (taken % 50 == 0)
                fast = ($urandom_range(0, 3) == 0);
            gap = fast ? 0 : $urandom_range(0, 19);
            if (taken == 300 || taken == 1200)
                gap = HOLD_CYCLES;
            @(negedge clk);
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            taken++;
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        wait (rst_n === 1'b1);
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("calibration_table_floor_lookup test failed");
        $finish;
    end

    initial
    begin
        table_model = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        items_issued = 0;
        sender_fast = 1'b0;
        narrow_keys = 1'b0;
        key_base = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        issue_item(OP_LOOKUP, 12'd0, 16'h0000, 16'h0000);
        issue_item(OP_UNUSED, 12'd4095, 16'hffff, 16'hffff);
        issue_item(OP_WRITE, 12'd2048, 16'h0000, 16'hffff);
        issue_item(OP_WRITE, 12'd0, 16'hffff, 16'h0000);
        issue_item(OP_WRITE, 12'd4095, 16'h1234, 16'h5678);
        issue_item(OP_LOOKUP, 12'd0, 16'h0000, 16'h0000);
        issue_item(OP_LOOKUP, 12'd4095, 16'h0000, 16'h0000);
        issue_item(OP_LOOKUP, 12'd2047, 16'h0000, 16'h0000);
        issue_item(OP_LOOKUP, 12'd3000, 16'h0000, 16'h0000);
        issue_item(OP_WRITE, 12'd2048, 16'haaaa, 16'h5555);
        issue_item(OP_LOOKUP, 12'd2048, 16'h0000, 16'h0000);
        issue_item(OP_CLEAR, 12'd0, 16'h0000, 16'h0000);
        issue_item(OP_LOOKUP, 12'd100, 16'h0000, 16'h0000);
        issue_item(OP_WRITE, 12'd500, 16'h0f0f, 16'hf0f0);
        issue_item(OP_LOOKUP, 12'd10, 16'h0000, 16'h0000);
        issue_item(OP_LOOKUP, 12'd4000, 16'h0000, 16'h0000);
        issue_item(OP_UNUSED, 12'd0, 16'h0000, 16'h0000);
        issue_item(OP_WRITE, 12'd700, 16'h8001, 16'h7ffe);
        issue_item(OP_LOOKUP, 12'd699, 16'h0000, 16'h0000);
        issue_item(OP_LOOKUP, 12'd701, 16'h0000, 16'h0000);
        issue_item(OP_CLEAR, 12'd4095, 16'hffff, 16'hffff);
        wait_drained();

        while (items_issued < ITEM_TARGET)
            run_episode();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (table_model.mismatch_count == 0)
            $display("calibration_table_floor_lookup test passed");
        else
            $display("calibration_table_floor_lookup test failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/ctfl_pkg.sv
rtl/ctfl_dpath.sv
rtl/ctfl_ctrl.sv
rtl/calibration_table_floor_lookup.sv
tb/sv/calibration_table_floor_lookup_tb.sv
